// ----- rtl/gdo_pkg.sv -----
// Shared types, constants and calendar helpers for the Gregorian date offset block.
`default_nettype none
package gdo_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 20;
  localparam int unsigned YEAR_W          = 14;
  localparam int unsigned MONTH_W         = 4;
  localparam int unsigned DAY_W           = 5;
  localparam int unsigned R400_W          = 9;   // year mod 400
  localparam int unsigned DOY_W           = 9;   // day of year, 0..365

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

  // year / 400 as (year * DIV400_MUL) >> DIV400_SHIFT, exact for 14-bit years
  localparam int unsigned DIV400_MUL_W = 13;
  localparam logic [DIV400_MUL_W-1:0] DIV400_MUL = DIV400_MUL_W'(5243);
  localparam int unsigned DIV400_SHIFT = 21;
  localparam int unsigned PROD_W = YEAR_W + DIV400_MUL_W;

  localparam logic [R400_W-1:0] R400_LAST = R400_W'(399);
  localparam logic [DOY_W-1:0]  YEAR_DAYS = DOY_W'(365);
  localparam logic [DOY_W-1:0]  LEAP_DAYS = DOY_W'(366);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DOY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_mod;
    logic calc_doy;
    logic year_step;
    logic set_oor;
    logic month_start;
    logic month_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic year_carry;
    logic year_edge;
    logic month_more;
    logic out_free;
  } sts_t;

  function automatic logic is_leap(input logic [1:0] ylow, input logic [R400_W-1:0] r400);
    is_leap = (ylow == 2'd0) && (r400 != R400_W'(100)) && (r400 != R400_W'(200)) &&
              (r400 != R400_W'(300));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m)
      4'd2:                      month_len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = DAY_W'(30);
      default:                   month_len = DAY_W'(31);
    endcase
  endfunction

  // days before the first of month m in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    days_before = DOY_W'(31);
      4'd3:    days_before = DOY_W'(59);
      4'd4:    days_before = DOY_W'(90);
      4'd5:    days_before = DOY_W'(120);
      4'd6:    days_before = DOY_W'(151);
      4'd7:    days_before = DOY_W'(181);
      4'd8:    days_before = DOY_W'(212);
      4'd9:    days_before = DOY_W'(243);
      4'd10:   days_before = DOY_W'(273);
      4'd11:   days_before = DOY_W'(304);
      4'd12:   days_before = DOY_W'(334);
      default: days_before = DOY_W'(0);
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gdo_req_if.sv -----
// Request channel: start date, day count and direction.
`default_nettype none
interface gdo_req_if import gdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [YEAR_W-1:0]      start_year;
  logic [MONTH_W-1:0]     start_month;
  logic [DAY_W-1:0]       start_day;
  logic [OFFSET_BITS-1:0] offset_days;

  modport source (output valid, mode, start_year, start_month, start_day, offset_days,
                  input ready);
  modport sink (input valid, mode, start_year, start_month, start_day, offset_days,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/gdo_rsp_if.sv -----
// Response channel: resulting date and range flag.
`default_nettype none
interface gdo_rsp_if import gdo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0]   result_day;
  logic               out_of_range;

  modport source (output valid, result_year, result_month, result_day, out_of_range,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, out_of_range,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/gregorian_date_offset.sv -----
// Top level of the Gregorian date offset block: sequencer plus datapath.
//
//   channel  dir  contents
//   req      in   mode, start_year, start_month, start_day, offset_days
//   rsp      out  result_year, result_month, result_day, out_of_range
//
// One word at a time: after the accept, year mod 400 and then the day of year
// are computed, the year loop crosses whole years, one year per cycle (about
// 2900 at most for a 20-bit offset), then up to 11 month steps in the final year.
// Stepping stops at year 1 or 9999 when the result leaves that range.
// Synchronous reset clears the sequencer and the output valid.
// A result waits in the output register; req is taken again once it is loaded.
`default_nettype none
module gregorian_date_offset import gdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gdo_req_if.sink   req,
  gdo_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdo_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (req.mode),
    .start_year   (req.start_year),
    .start_month  (req.start_month),
    .start_day    (req.start_day),
    .offset_days  (req.offset_days),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_year  (rsp.result_year),
    .result_month (rsp.result_month),
    .result_day   (rsp.result_day),
    .out_of_range (rsp.out_of_range)
  );

`ifndef SYNTHESIS
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !req.ready)
    else $error("request taken while a word is in progress");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.year_step, cmd.month_step, cmd.finish, cmd.set_oor}))
    else $error("conflicting datapath commands");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp.valid)
    else $error("finished word not presented");

  a_oor_clamp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_of_range) |->
      ((rsp.result_year == YEAR_MIN && rsp.result_month == MONTH_JAN &&
        rsp.result_day == DAY_FIRST) ||
       (rsp.result_year == YEAR_MAX && rsp.result_month == MONTH_DEC &&
        rsp.result_day == DAY_LAST)))
    else $error("out of range word not clamped");
`endif

endmodule
`default_nettype wire

// ----- rtl/gdo_ctrl.sv -----
// Sequencer for the date offset: load, year steps, month steps, output.
`default_nettype none
module gdo_ctrl import gdo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_valid) state_next = ST_MOD;
      ST_MOD:   state_next = ST_DOY;
      ST_DOY:   state_next = ST_YEAR;
      ST_YEAR: begin
        if (!sts.year_carry) state_next = ST_MONTH;
        else if (sts.year_edge) state_next = ST_DONE;
      end
      ST_MONTH: if (!sts.month_more) state_next = ST_DONE;
      ST_DONE:  if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_MOD:   cmd.calc_mod = 1'b1;
      ST_DOY:   cmd.calc_doy = 1'b1;
      ST_YEAR: begin
        if (!sts.year_carry) cmd.month_start = 1'b1;
        else if (sts.year_edge) cmd.set_oor = 1'b1;
        else cmd.year_step = 1'b1;
      end
      ST_MONTH: cmd.month_step = sts.month_more;
      ST_DONE:  cmd.finish = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/gdo_datapath.sv -----
// Datapath: clamping, year-mod-400 tracking, day counter and output register.
`default_nettype none
module gdo_datapath import gdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   mode,
  input  logic [YEAR_W-1:0]      start_year,
  input  logic [MONTH_W-1:0]     start_month,
  input  logic [DAY_W-1:0]       start_day,
  input  logic [OFFSET_BITS-1:0] offset_days,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic [YEAR_W-1:0]      result_year,
  output logic [MONTH_W-1:0]     result_month,
  output logic [DAY_W-1:0]       result_day,
  output logic                   out_of_range
);

  // signed day count relative to Jan 1 of the current year
  localparam int unsigned TW = OFFSET_BITS + 2;

  logic                   sub;
  logic [YEAR_W-1:0]      year;
  logic [MONTH_W-1:0]     month;
  logic [DAY_W-1:0]       day_in;
  logic [OFFSET_BITS-1:0] offset;
  logic [PROD_W-1:0]      prod;
  logic [R400_W-1:0]      r400;
  logic [TW-1:0]          t;
  logic                   oor;

  logic [YEAR_W-1:0]  year_cl, q400, year_dn, year_up;
  logic [MONTH_W-1:0] month_cl;
  logic [R400_W-1:0]  r400_dn, r400_up;
  logic               leap, leap_dn;
  logic [DOY_W-1:0]   ylen, ylen_dn, doy;
  logic [DAY_W-1:0]   mlen, day_cl;
  logic               out_free;

  always_comb begin
    if (start_year < YEAR_MIN) year_cl = YEAR_MIN;
    else if (start_year > YEAR_MAX) year_cl = YEAR_MAX;
    else year_cl = start_year;
    if (start_month < MONTH_JAN) month_cl = MONTH_JAN;
    else if (start_month > MONTH_DEC) month_cl = MONTH_DEC;
    else month_cl = start_month;
  end

  assign q400    = YEAR_W'(prod >> DIV400_SHIFT);
  assign year_dn = year - YEAR_W'(1);
  assign year_up = year + YEAR_W'(1);
  assign r400_dn = (r400 == '0) ? R400_LAST : r400 - R400_W'(1);
  assign r400_up = (r400 == R400_LAST) ? '0 : r400 + R400_W'(1);
  assign leap    = is_leap(year[1:0], r400);
  assign leap_dn = is_leap(year_dn[1:0], r400_dn);
  assign ylen    = leap ? LEAP_DAYS : YEAR_DAYS;
  assign ylen_dn = leap_dn ? LEAP_DAYS : YEAR_DAYS;
  assign mlen    = month_len(month, leap);

  always_comb begin
    if (day_in == '0) day_cl = DAY_FIRST;
    else if (day_in > mlen) day_cl = mlen;
    else day_cl = day_in;
    doy = days_before(month) + DOY_W'(day_cl) - DOY_W'(1);
    if (leap && (month > MONTH_FEB)) doy = doy + DOY_W'(1);
  end

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    if (sub) begin
      sts.year_carry = t[TW-1];
      sts.year_edge  = (year == YEAR_MIN);
    end else begin
      sts.year_carry = (t >= TW'(ylen));
      sts.year_edge  = (year == YEAR_MAX);
    end
    sts.month_more = (month != MONTH_DEC) && (t >= TW'(mlen));
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sub    <= mode;
      year   <= year_cl;
      month  <= month_cl;
      day_in <= start_day;
      offset <= offset_days;
      prod   <= PROD_W'(year_cl) * PROD_W'(DIV400_MUL);
      oor    <= 1'b0;
    end
    if (cmd.calc_mod) begin
      r400 <= R400_W'(year - q400 * YEAR_W'(400));
    end
    if (cmd.calc_doy) begin
      t <= sub ? TW'(doy) - TW'(offset) : TW'(doy) + TW'(offset);
    end
    if (cmd.year_step) begin
      if (sub) begin
        year <= year_dn;
        r400 <= r400_dn;
        t    <= t + TW'(ylen_dn);
      end else begin
        year <= year_up;
        r400 <= r400_up;
        t    <= t - TW'(ylen);
      end
    end
    if (cmd.set_oor) begin
      oor <= 1'b1;
    end
    if (cmd.month_start) begin
      month <= MONTH_JAN;
    end
    if (cmd.month_step) begin
      month <= month + MONTH_W'(1);
      t     <= t - TW'(mlen);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_of_range <= oor;
      if (oor && sub) begin
        result_year  <= YEAR_MIN;
        result_month <= MONTH_JAN;
        result_day   <= DAY_FIRST;
      end else if (oor) begin
        result_year  <= YEAR_MAX;
        result_month <= MONTH_DEC;
        result_day   <= DAY_LAST;
      end else begin
        result_year  <= year;
        result_month <= month;
        result_day   <= DAY_W'(t) + DAY_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for gregorian_date_offset: directed calendar cases plus random dates, self-checking.
module tb;
  import gdo_pkg::*;

  localparam int unsigned OFFSET_BITS = OFFSET_BITS_DEF;
  localparam longint DAYS_400Y = 146097;
  localparam longint DAYS_100Y = 36524;
  localparam longint DAYS_4Y   = 1461;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               out_of_range;
  } date_result_t;

  logic clk;
  logic rst;

  gdo_req_if #(.OFFSET_BITS(OFFSET_BITS)) req ();
  gdo_rsp_if rsp ();

  gregorian_date_offset #(.OFFSET_BITS(OFFSET_BITS)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  date_result_t expected_dates[$];
  int errors_seen;
  int dates_sent;
  int dates_clamped;
  int dates_past_range;
  bit idling_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // day count since 0001-01-01
  function automatic longint day_number(int y, int m, int d);
    longint n;
    int p;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int k = 1; k < m; k++) n += month_days(y, k);
    return n + d - 1;
  endfunction

  function automatic date_result_t predict_date(input logic dir,
                                                input logic [YEAR_W-1:0] y_in,
                                                input logic [MONTH_W-1:0] m_in,
                                                input logic [DAY_W-1:0] d_in,
                                                input logic [OFFSET_BITS-1:0] span,
                                                output bit clamped);
    int y, m, d;
    longint n, r, q400, q100, q4, q1;
    date_result_t res;
    y = int'(y_in);
    m = int'(m_in);
    d = int'(d_in);
    clamped = 1'b0;
    if (y < 1) begin y = 1; clamped = 1'b1; end
    if (y > 9999) begin y = 9999; clamped = 1'b1; end
    if (m < 1) begin m = 1; clamped = 1'b1; end
    if (m > 12) begin m = 12; clamped = 1'b1; end
    if (d < 1) begin d = 1; clamped = 1'b1; end
    if (d > month_days(y, m)) begin d = month_days(y, m); clamped = 1'b1; end
    n = day_number(y, m, d);
    n = dir ? n - longint'(span) : n + longint'(span);
    if (n < 0) begin
      res = '{YEAR_MIN, MONTH_JAN, DAY_FIRST, 1'b1};
    end else if (n > day_number(9999, 12, 31)) begin
      res = '{YEAR_MAX, MONTH_DEC, DAY_LAST, 1'b1};
    end else begin
      q400 = n / DAYS_400Y;
      r    = n % DAYS_400Y;
      q100 = r / DAYS_100Y;
      if (q100 > 3) q100 = 3;  // last day of a 400-year cycle
      r   -= q100 * DAYS_100Y;
      q4   = r / DAYS_4Y;
      r    = r % DAYS_4Y;
      q1   = r / 365;
      if (q1 > 3) q1 = 3;      // leap day at the end of a 4-year block
      r   -= q1 * 365;
      y = int'(400 * q400 + 100 * q100 + 4 * q4 + q1 + 1);
      m = 1;
      while (m < 12 && r >= month_days(y, m)) begin
        r -= month_days(y, m);
        m++;
      end
      res.year         = YEAR_W'(y);
      res.month        = MONTH_W'(m);
      res.day          = DAY_W'(r + 1);
      res.out_of_range = 1'b0;
    end
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int pick;
    if (!idling_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_date(input logic dir, input logic [YEAR_W-1:0] y,
                           input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                           input logic [OFFSET_BITS-1:0] span);
    int gap;
    bit clamped;
    date_result_t res;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid       = 1'b1;
    req.mode        = dir;
    req.start_year  = y;
    req.start_month = m;
    req.start_day   = d;
    req.offset_days = span;
    do @(posedge clk); while (!req.ready);
    res = predict_date(dir, y, m, d, span, clamped);
    expected_dates.push_back(res);
    dates_sent++;
    if (clamped) dates_clamped++;
    if (res.out_of_range) dates_past_range++;
  endtask

  task automatic send_random_date();
    logic [YEAR_W-1:0] y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d;
    logic [OFFSET_BITS-1:0] span;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // raw field noise, clamping paths
      y = YEAR_W'($urandom);
      m = MONTH_W'($urandom);
      d = DAY_W'($urandom);
    end else begin
      if (pick < 22) y = YEAR_W'($urandom_range(1, 30));
      else if (pick < 29) y = YEAR_W'($urandom_range(9970, 9999));
      else y = YEAR_W'($urandom_range(1, 9999));
      m = MONTH_W'($urandom_range(1, 12));
      d = DAY_W'($urandom_range(1, month_days(int'(y), int'(m))));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) span = OFFSET_BITS'($urandom_range(0, 400));
    else if (pick < 70) span = OFFSET_BITS'($urandom_range(0, 40000));
    else span = OFFSET_BITS'($urandom);
    send_date(1'($urandom), y, m, d, span);
  endtask

  task automatic test_calendar_edges();
    idling_on = 1'b0;
    send_date(1'b0, 14'd2000, 4'd2, 5'd28, 20'd1);    // into leap day
    send_date(1'b0, 14'd1900, 4'd2, 5'd28, 20'd1);    // century, no leap day
    send_date(1'b0, 14'd2023, 4'd12, 5'd31, 20'd1);   // year-end rollover
    send_date(1'b0, 14'd2024, 4'd12, 5'd31, 20'd0);
    send_date(1'b1, 14'd2024, 4'd1, 5'd1, 20'd1);     // back across year end
    send_date(1'b1, 14'd2000, 4'd3, 5'd1, 20'd1);
    send_date(1'b1, 14'd2000, 4'd2, 5'd29, 20'd366);
    send_date(1'b0, 14'd2400, 4'd12, 5'd31, 20'd366);
    send_date(1'b1, 14'd1, 4'd1, 5'd1, 20'd1);        // below year 1
    send_date(1'b0, 14'd9999, 4'd12, 5'd31, 20'd1);   // above year 9999
    send_date(1'b0, 14'd1, 4'd1, 5'd1, 20'hFFFFF);
    send_date(1'b1, 14'd9999, 4'd12, 5'd31, 20'hFFFFF);
    send_date(1'b1, 14'd1, 4'd1, 5'd1, 20'd0);
    send_date(1'b0, 14'd9999, 4'd12, 5'd31, 20'd0);
  endtask

  task automatic test_field_clamping();
    idling_on = 1'b0;
    send_date(1'b0, 14'd0, 4'd6, 5'd15, 20'd10);
    send_date(1'b1, 14'h3FFF, 4'd6, 5'd15, 20'd10);
    send_date(1'b0, 14'd2021, 4'd0, 5'd10, 20'd5);
    send_date(1'b0, 14'd2021, 4'hF, 5'd10, 20'd5);
    send_date(1'b0, 14'd2021, 4'd5, 5'd0, 20'd3);
    send_date(1'b0, 14'd2024, 4'd2, 5'd31, 20'd1);    // Feb 31 of a leap year
    send_date(1'b0, 14'd2100, 4'd2, 5'd29, 20'd1);
    send_date(1'b1, 14'd2022, 4'd4, 5'd31, 20'd30);
  endtask

  task automatic test_random_back_to_back();
    idling_on = 1'b0;
    repeat (50) send_random_date();
  endtask

  task automatic test_random_with_stalls();
    idling_on = 1'b1;
    repeat (150) send_random_date();
  endtask

  // result side backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp.ready = 1'b0;
      end else if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else begin
        rsp.ready = 1'b1;
        stall_left = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    date_result_t exp_res;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_dates.size() == 0) begin
        $error("unexpected result word %0d-%0d-%0d", rsp.result_year, rsp.result_month,
               rsp.result_day);
        errors_seen++;
      end else begin
        exp_res = expected_dates.pop_front();
        if (rsp.result_year !== exp_res.year) begin
          $error("result_year: expected %0d, actual %0d", exp_res.year, rsp.result_year);
          errors_seen++;
        end
        if (rsp.result_month !== exp_res.month) begin
          $error("result_month: expected %0d, actual %0d", exp_res.month, rsp.result_month);
          errors_seen++;
        end
        if (rsp.result_day !== exp_res.day) begin
          $error("result_day: expected %0d, actual %0d", exp_res.day, rsp.result_day);
          errors_seen++;
        end
        if (rsp.out_of_range !== exp_res.out_of_range) begin
          $error("out_of_range: expected %0d, actual %0d", exp_res.out_of_range,
                 rsp.out_of_range);
          errors_seen++;
        end
      end
    end
  end

  initial begin
    errors_seen      = 0;
    dates_sent       = 0;
    dates_clamped    = 0;
    dates_past_range = 0;
    idling_on        = 1'b0;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.mode         = 1'b0;
    req.start_year   = '0;
    req.start_month  = '0;
    req.start_day    = '0;
    req.offset_days  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_calendar_edges();
    test_field_clamping();
    test_random_back_to_back();
    test_random_with_stalls();

    @(negedge clk);
    req.valid = 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d dates: %0d with clamped start fields, %0d past the year range.",
             dates_sent, dates_clamped, dates_past_range);
    $display("Directed leap, century and year-end cases, then random dates with and without gaps.");
    if (errors_seen == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
